[rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds whenever the trigger holds, in the same cycle.
`define ASSERT_IMPL(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed: same-cycle implication");

// The condition holds starting in the cycle after the trigger.
`define ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/iftf_pkg.sv]
`default_nettype none
package iftf_pkg;

  localparam int INTERNAL_PRECISION = 14;
  localparam int FILTER_PRECISION   = 6;

  localparam int NUM_TAPS  = 8;
  localparam int SAMPLE_W  = 16;
  localparam int TAP_W     = 8;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DEPTH_W   = 4;

  // Product of one sample and one tap, then the widths of the adder tree.
  localparam int PROD_W = SAMPLE_W + TAP_W;
  localparam int SUM_W  = PROD_W + $clog2(NUM_TAPS);
  // Largest offset magnitude is 2^(IP-1+FP) plus the rounding term.
  localparam int OFFS_W = INTERNAL_PRECISION + FILTER_PRECISION + 1;
  localparam int ACC_W  = ((SUM_W > OFFS_W) ? SUM_W : OFFS_W) + 1;
  // Largest shift is FP plus the largest headroom, which is FP.
  localparam int SHIFT_W = $clog2(2 * FILTER_PRECISION + 1);

  localparam int DEPTH_MIN = INTERNAL_PRECISION - FILTER_PRECISION;
  localparam int DEPTH_MAX = INTERNAL_PRECISION;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAPS_LOW    = 3'd0,
    REG_TAPS_HIGH   = 3'd1,
    REG_EIGHT_TAPS  = 3'd2,
    REG_FIRST_STAGE = 3'd3,
    REG_LAST_STAGE  = 3'd4,
    REG_BIT_DEPTH   = 3'd5
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Accumulator handed from the MAC pipeline to the output stage.
  typedef struct packed {
    logic                    valid;
    logic signed [ACC_W-1:0] acc;
  } acc_t;

  // Bit depth saturated into the supported range.
  function automatic logic [DEPTH_W-1:0] sat_depth(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W-1:0] r;
    r = d;
    if (d < DEPTH_W'(DEPTH_MIN)) r = DEPTH_W'(DEPTH_MIN);
    if (d > DEPTH_W'(DEPTH_MAX)) r = DEPTH_W'(DEPTH_MAX);
    return r;
  endfunction

  function automatic logic [SHIFT_W-1:0] stage_shift(input logic first,
                                                     input logic last,
                                                     input logic [DEPTH_W-1:0] depth);
    logic [SHIFT_W-1:0] headroom;
    logic [SHIFT_W-1:0] r;
    headroom = SHIFT_W'(INTERNAL_PRECISION) - SHIFT_W'(depth);
    r = SHIFT_W'(FILTER_PRECISION);
    if (last && !first) r = SHIFT_W'(FILTER_PRECISION) + headroom;
    if (!last && first) r = SHIFT_W'(FILTER_PRECISION) - headroom;
    return r;
  endfunction

  function automatic logic signed [OFFS_W-1:0] stage_offset(input logic first,
                                                            input logic last,
                                                            input logic [SHIFT_W-1:0] shift);
    logic signed [OFFS_W-1:0] one;
    logic signed [OFFS_W-1:0] ioffs;
    logic signed [OFFS_W-1:0] r;
    one   = OFFS_W'(1);
    ioffs = one <<< (INTERNAL_PRECISION - 1);
    r     = '0;
    if (last) begin
      r = one <<< (shift - SHIFT_W'(1));
      if (!first) r = r + (ioffs <<< FILTER_PRECISION);
    end else if (first) begin
      r = -(ioffs <<< shift);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/iftf_mac.sv]
`default_nettype none
`include "assert_macros.svh"
// Four-stage multiply and adder tree: products, pair sums, quad sums, total plus offset.
module iftf_mac (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          in_valid,
  input  wire iftf_pkg::sample_t                             samples [iftf_pkg::NUM_TAPS],
  input  wire logic [iftf_pkg::NUM_TAPS*iftf_pkg::TAP_W-1:0] taps,
  input  wire logic                                          eight_taps,
  input  wire logic signed [iftf_pkg::OFFS_W-1:0]            offset,
  output iftf_pkg::acc_t                                     acc
);

  localparam int N      = iftf_pkg::NUM_TAPS;
  localparam int PROD_W = iftf_pkg::PROD_W;
  localparam int ACC_W  = iftf_pkg::ACC_W;
  localparam int TAP_W  = iftf_pkg::TAP_W;

  logic signed [PROD_W-1:0] prod_r   [N];
  logic signed [PROD_W-1:0] prod_nxt [N];
  logic signed [PROD_W:0]   pair_r   [N/2];
  logic signed [PROD_W:0]   pair_nxt [N/2];
  logic signed [PROD_W+1:0] quad_r   [N/4];
  logic signed [PROD_W+1:0] quad_nxt [N/4];
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic [3:0]               valid_r;
  logic [3:0]               valid_nxt;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (eight_taps || i < N / 2) begin
        prod_nxt[i] = PROD_W'(samples[i] * $signed(taps[i*TAP_W +: TAP_W]));
      end else begin
        prod_nxt[i] = '0;
      end
    end
    for (int j = 0; j < N / 2; j++) begin
      pair_nxt[j] = (PROD_W+1)'(prod_r[2*j]) + (PROD_W+1)'(prod_r[2*j+1]);
    end
    for (int k = 0; k < N / 4; k++) begin
      quad_nxt[k] = (PROD_W+2)'(pair_r[2*k]) + (PROD_W+2)'(pair_r[2*k+1]);
    end
    acc_nxt   = ACC_W'(quad_r[0]) + ACC_W'(quad_r[1]) + ACC_W'(offset);
    valid_nxt = {valid_r[2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    pair_r <= pair_nxt;
    quad_r <= quad_nxt;
    acc_r  <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign acc.valid = valid_r[3];
  assign acc.acc   = acc_r;

  // With four taps the upper products must not contribute.
  `ASSERT_IMPL(a_four_tap_mask, valid_r[0] && !eight_taps, prod_r[4] == '0 && prod_r[5] == '0 && prod_r[6] == '0 && prod_r[7] == '0)
  // A product moves on to the pair sums in the next cycle.
  `ASSERT_NEXT(a_first_advance, valid_r[0], valid_r[1])
  // A quad sum reaches the accumulator output in the next cycle.
  `ASSERT_NEXT(a_last_advance, valid_r[2], acc.valid)

endmodule
`default_nettype wire

[rtl/interpolation_fir_tap_filter.sv]
`default_nettype none
`include "assert_macros.svh"
// Channel   Ports                                   Handshake
// input     start, busy, in_sample_0..7             taken when start && !busy
// result    out_valid, out_filtered_sample          one-cycle strobe, always taken
// config    cfg_we, cfg_index, cfg_data             written when cfg_we is high
//
// The filter is a five-stage pipeline taking one item every cycle while busy is low.
// A result reaches out_valid via the product, pair, quad, acc and result registers.
// Synchronous reset clears the valid bits and sets the config defaults; busy is high
// in reset, is cleared once reset is released, and stays low from then on.
// The receiver cannot stall, so the pipeline never holds and no item is dropped.
module interpolation_fir_tap_filter (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [iftf_pkg::SAMPLE_W-1:0]  in_sample_0,
  input  wire logic signed [iftf_pkg::SAMPLE_W-1:0]  in_sample_1,
  input  wire logic signed [iftf_pkg::SAMPLE_W-1:0]  in_sample_2,
  input  wire logic signed [iftf_pkg::SAMPLE_W-1:0]  in_sample_3,
  input  wire logic signed [iftf_pkg::SAMPLE_W-1:0]  in_sample_4,
  input  wire logic signed [iftf_pkg::SAMPLE_W-1:0]  in_sample_5,
  input  wire logic signed [iftf_pkg::SAMPLE_W-1:0]  in_sample_6,
  input  wire logic signed [iftf_pkg::SAMPLE_W-1:0]  in_sample_7,
  output logic                                       out_valid,
  output logic signed [iftf_pkg::SAMPLE_W-1:0]       out_filtered_sample,
  input  wire logic                                  cfg_we,
  input  wire logic [iftf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [iftf_pkg::CFG_W-1:0]            cfg_data
);

  localparam int SAMPLE_W = iftf_pkg::SAMPLE_W;
  localparam int DEPTH_W  = iftf_pkg::DEPTH_W;
  localparam int SHIFT_W  = iftf_pkg::SHIFT_W;
  localparam int ACC_W    = iftf_pkg::ACC_W;

  // Configuration registers. The user must change them only while the pipeline
  // is empty, not enforced here; derived shift, offset and clip limit are plain logic.
  logic [iftf_pkg::CFG_W-1:0] taps_low_r;
  logic [iftf_pkg::CFG_W-1:0] taps_high_r;
  logic                       eight_taps_r;
  logic                       first_stage_r;
  logic                       last_stage_r;
  logic [DEPTH_W-1:0]         bit_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_low_r    <= '0;
      taps_high_r   <= '0;
      eight_taps_r  <= 1'b1;
      first_stage_r <= 1'b1;
      last_stage_r  <= 1'b1;
      bit_depth_r   <= DEPTH_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        iftf_pkg::REG_TAPS_LOW:    taps_low_r    <= cfg_data;
        iftf_pkg::REG_TAPS_HIGH:   taps_high_r   <= cfg_data;
        iftf_pkg::REG_EIGHT_TAPS:  eight_taps_r  <= cfg_data[0];
        iftf_pkg::REG_FIRST_STAGE: first_stage_r <= cfg_data[0];
        iftf_pkg::REG_LAST_STAGE:  last_stage_r  <= cfg_data[0];
        iftf_pkg::REG_BIT_DEPTH:   bit_depth_r   <= cfg_data[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Busy only guards the cycles around reset; afterwards every start is taken.
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  logic                            accept;
  logic [DEPTH_W-1:0]              depth;
  logic [SHIFT_W-1:0]              shift;
  logic signed [iftf_pkg::OFFS_W-1:0] offset;
  logic [SAMPLE_W-1:0]             max_pixel;

  assign accept    = start && !busy_r;
  assign depth     = iftf_pkg::sat_depth(bit_depth_r);
  assign shift     = iftf_pkg::stage_shift(first_stage_r, last_stage_r, depth);
  assign offset    = iftf_pkg::stage_offset(first_stage_r, last_stage_r, shift);
  assign max_pixel = (SAMPLE_W'(1) << depth) - SAMPLE_W'(1);

  iftf_pkg::sample_t samples [iftf_pkg::NUM_TAPS];

  assign samples[0] = in_sample_0;
  assign samples[1] = in_sample_1;
  assign samples[2] = in_sample_2;
  assign samples[3] = in_sample_3;
  assign samples[4] = in_sample_4;
  assign samples[5] = in_sample_5;
  assign samples[6] = in_sample_6;
  assign samples[7] = in_sample_7;

  // Stages one to four: products, two adder-tree levels, and total plus offset.
  iftf_pkg::acc_t mac_out;

  iftf_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .samples    (samples),
    .taps       ({taps_high_r, taps_low_r}),
    .eight_taps (eight_taps_r),
    .offset     (offset),
    .acc        (mac_out)
  );

  // Stage five: arithmetic shift (floor), wrap to 16 bits, and clip on the last stage.
  logic signed [ACC_W-1:0]    shifted;
  logic signed [SAMPLE_W-1:0] wrapped;
  logic signed [SAMPLE_W-1:0] result_nxt;
  logic signed [SAMPLE_W-1:0] result_r;
  logic                       out_valid_r;

  always_comb begin
    shifted    = mac_out.acc >>> shift;
    wrapped    = shifted[SAMPLE_W-1:0];
    result_nxt = wrapped;
    if (last_stage_r) begin
      if (wrapped < 0) begin
        result_nxt = '0;
      end else if ($unsigned(wrapped) > max_pixel) begin
        result_nxt = $signed(max_pixel);
      end
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mac_out.valid;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = result_r;

  // Every item taken comes out on out_valid.
  `ASSERT_NEXT(a_latency, accept, ##4 out_valid)
  // A result never appears without a matching item taken before it.
  `ASSERT_IMPL(a_no_phantom, out_valid, $past(accept, 5))
  // On the last stage every result lies in the pixel range.
  `ASSERT_IMPL(a_clip_range, out_valid && last_stage_r, out_filtered_sample >= 0 && $unsigned(out_filtered_sample) <= max_pixel)

endmodule
`default_nettype wire
